@@ rtl/bdq_pkg.sv @@
// shared types and constants for the bounded deque with delete
package bdq_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;
    localparam int VALUE_W            = 32;
    localparam int COUNT_OUT_W        = 5;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_BACK   = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_DELETE     = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_APPEND    = 3'd1,
        CMD_SHIFT_IN  = 3'd2,
        CMD_SHIFT_OUT = 3'd3,
        CMD_DELETE    = 3'd4
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic at_back;
        logic occupied;
    } cell_ctl_t;

endpackage

@@ rtl/bdq_cell.sv @@
// one storage cell of the deque chain with compare and neighbor shift
module bdq_cell #(
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  bdq_pkg::cell_ctl_t    ctl,
    input  logic [DATA_WIDTH-1:0] word,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic                  prefix_in,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  prefix_out
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  match;

    assign match      = ctl.occupied && (data_reg == word);
    assign prefix_out = prefix_in | match;
    assign data       = data_reg;

    always_comb
    begin
        unique case (ctl.cmd)
            bdq_pkg::CMD_NONE:      data_next = data_reg;
            bdq_pkg::CMD_APPEND:    data_next = ctl.at_back ? word : data_reg;
            bdq_pkg::CMD_SHIFT_IN:  data_next = left_data;
            bdq_pkg::CMD_SHIFT_OUT: data_next = right_data;
            bdq_pkg::CMD_DELETE:    data_next = prefix_out ? right_data : data_reg;
            default:                data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

@@ rtl/bounded_deque_with_delete_core.sv @@
// top level of the bounded deque with delete: cell chain, count and result register
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------
//  in      | in_valid  | in_stall  | opcode, value
//  out     | out_valid | out_stall | removed_value, item_count, status
//
// the cell chain compares and shifts in parallel, so a new transaction can be taken
// each cycle while in_stall is low
// the result lands in an output register in the cycle after acceptance
// reset clears the count and the output valid; cell contents stay undefined
// in_stall is high only while a result is held and out_stall is high
module bounded_deque_with_delete_core #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        opcode,
    input  logic [bdq_pkg::VALUE_W-1:0]       value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bdq_pkg::VALUE_W-1:0]       removed_value,
    output logic [bdq_pkg::COUNT_OUT_W-1:0]   item_count,
    output logic [1:0]                        status
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DATA_WIDTH-1:0] removed_reg;
    logic [DATA_WIDTH-1:0] removed_next;
    bdq_pkg::status_t      status_reg;
    bdq_pkg::status_t      status_next;

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  found;
    bdq_pkg::cmd_t         cmd;
    logic [63:0]           value_ext;
    logic [DATA_WIDTH-1:0] word;
    logic [DATA_WIDTH-1:0] back_data;
    logic [63:0]           removed_ext;
    logic [15:0]           count_ext;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] back_sel  [DEPTH];
    logic                  prefix_chain [DEPTH+1];

    assign accept    = in_valid && !in_stall;
    assign in_stall  = out_valid_reg && out_stall;
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign found     = prefix_chain[DEPTH];
    assign value_ext = {32'd0, value};
    assign word      = value_ext[DATA_WIDTH-1:0];

    assign prefix_chain[0] = 1'b0;

    // cell chain
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        bdq_pkg::cell_ctl_t    ctl;
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        assign ctl.cmd      = cmd;
        assign ctl.at_back  = (count_reg == CW'(i));
        assign ctl.occupied = (CW'(i) < count_reg);

        if (i == 0) begin : g_first
            assign left_data = word;
        end else begin : g_mid_left
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_data = cell_data[i];
        end else begin : g_mid_right
            assign right_data = cell_data[i+1];
        end

        assign back_sel[i] = (count_reg == CW'(i + 1)) ? cell_data[i] : '0;

        bdq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .word       (word),
            .left_data  (left_data),
            .right_data (right_data),
            .prefix_in  (prefix_chain[i]),
            .data       (cell_data[i]),
            .prefix_out (prefix_chain[i+1])
        );
    end

    always_comb
    begin
        back_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            back_data = back_data | back_sel[i];
        end
    end

    // operation decode
    always_comb
    begin
        cmd          = bdq_pkg::CMD_NONE;
        count_next   = count_reg;
        removed_next = '0;
        status_next  = bdq_pkg::ST_OK;
        unique case (bdq_pkg::op_t'(opcode))
            bdq_pkg::OP_PUSH_BACK:
            begin
                if (full) begin
                    status_next = bdq_pkg::ST_FULL;
                end else begin
                    cmd        = bdq_pkg::CMD_APPEND;
                    count_next = count_reg + CW'(1);
                end
            end
            bdq_pkg::OP_POP_BACK:
            begin
                if (empty) begin
                    status_next = bdq_pkg::ST_EMPTY;
                end else begin
                    removed_next = back_data;
                    count_next   = count_reg - CW'(1);
                end
            end
            bdq_pkg::OP_PUSH_FRONT:
            begin
                if (full) begin
                    status_next = bdq_pkg::ST_FULL;
                end else begin
                    cmd        = bdq_pkg::CMD_SHIFT_IN;
                    count_next = count_reg + CW'(1);
                end
            end
            bdq_pkg::OP_POP_FRONT:
            begin
                if (empty) begin
                    status_next = bdq_pkg::ST_EMPTY;
                end else begin
                    cmd          = bdq_pkg::CMD_SHIFT_OUT;
                    removed_next = cell_data[0];
                    count_next   = count_reg - CW'(1);
                end
            end
            bdq_pkg::OP_DELETE:
            begin
                cmd = bdq_pkg::CMD_DELETE;
                if (found) begin
                    count_next = count_reg - CW'(1);
                end else begin
                    status_next = bdq_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                cmd = bdq_pkg::CMD_NONE;
            end
        endcase
        if (!accept) begin
            cmd        = bdq_pkg::CMD_NONE;
            count_next = count_reg;
        end
    end

    assign out_valid_next = accept || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            removed_reg <= removed_next;
            status_reg  <= status_next;
        end
    end

    always_comb
    begin
        removed_ext                 = '0;
        removed_ext[DATA_WIDTH-1:0] = removed_reg;
        count_ext                   = '0;
        count_ext[CW-1:0]           = count_reg;
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = removed_ext[bdq_pkg::VALUE_W-1:0];
    assign item_count    = count_ext[bdq_pkg::COUNT_OUT_W-1:0];
    assign status        = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count above depth");

    a_delete_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == bdq_pkg::CMD_DELETE && found)
        |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("delete hit did not shrink count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == bdq_pkg::ST_FULL) |-> full)
        else $error("full status without full queue");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != bdq_pkg::ST_OK) |-> (removed_reg == '0))
        else $error("failed transaction returned data");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted transaction lost its result");

endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench for the bounded deque with delete
module tb;

    localparam int DEPTH = bdq_pkg::DEPTH_DEFAULT;
    localparam logic [2:0] OP_RESERVED_LO = 3'd5;
    localparam logic [2:0] OP_RESERVED_HI = 3'd7;
    localparam int NUM_RANDOM = 1200;
    localparam int LONG_HOLD = 60;

    typedef struct packed {
        logic [bdq_pkg::VALUE_W-1:0]     removed;
        logic [bdq_pkg::COUNT_OUT_W-1:0] count;
        bdq_pkg::status_t                st;
    } deque_result_t;

    class deque_scoreboard;
        logic [bdq_pkg::VALUE_W-1:0] held [DEPTH];
        int                          occupancy;
        deque_result_t               waiting [$];
        int                          errors;

        function new();
            occupancy = 0;
            errors    = 0;
        endfunction

        function void note_request(logic [2:0] op, logic [bdq_pkg::VALUE_W-1:0] word);
            deque_result_t r;
            int            i;
            int            hit;
            r.removed = '0;
            r.st      = bdq_pkg::ST_OK;
            case (op)
                bdq_pkg::OP_PUSH_BACK, bdq_pkg::OP_PUSH_FRONT:
                begin
                    if (occupancy >= DEPTH) begin
                        r.st = bdq_pkg::ST_FULL;
                    end else if (op == bdq_pkg::OP_PUSH_BACK) begin
                        held[occupancy] = word;
                        occupancy++;
                    end else begin
                        for (i = occupancy; i > 0; i--) held[i] = held[i-1];
                        held[0] = word;
                        occupancy++;
                    end
                end
                bdq_pkg::OP_POP_BACK:
                begin
                    if (occupancy == 0) begin
                        r.st = bdq_pkg::ST_EMPTY;
                    end else begin
                        occupancy--;
                        r.removed = held[occupancy];
                    end
                end
                bdq_pkg::OP_POP_FRONT:
                begin
                    if (occupancy == 0) begin
                        r.st = bdq_pkg::ST_EMPTY;
                    end else begin
                        r.removed = held[0];
                        for (i = 0; i < occupancy - 1; i++) held[i] = held[i+1];
                        occupancy--;
                    end
                end
                bdq_pkg::OP_DELETE:
                begin
                    hit = -1;
                    for (i = 0; i < occupancy; i++) begin
                        if (hit < 0 && held[i] == word) hit = i;
                    end
                    if (hit < 0) begin
                        r.st = bdq_pkg::ST_NOT_FOUND;
                    end else begin
                        for (i = hit; i < occupancy - 1; i++) held[i] = held[i+1];
                        occupancy--;
                    end
                end
                default:
                begin
                end
            endcase
            r.count = bdq_pkg::COUNT_OUT_W'(occupancy);
            waiting.push_back(r);
        endfunction

        function void check_result(logic [bdq_pkg::VALUE_W-1:0] rv,
                                   logic [bdq_pkg::COUNT_OUT_W-1:0] cnt,
                                   logic [1:0] st);
            deque_result_t e;
            if (waiting.size() == 0) begin
                $error("result with no transaction outstanding");
                errors++;
                return;
            end
            e = waiting.pop_front();
            if (rv !== e.removed) begin
                $error("removed_value: expected %h, got %h", e.removed, rv);
                errors++;
            end
            if (cnt !== e.count) begin
                $error("item_count: expected %0d, got %0d", e.count, cnt);
                errors++;
            end
            if (st !== e.st) begin
                $error("status: expected %0d, got %0d", e.st, st);
                errors++;
            end
        endfunction

        function int pending();
            return waiting.size();
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [2:0]                      opcode;
    logic [bdq_pkg::VALUE_W-1:0]     value;
    logic                            out_valid;
    logic                            out_stall;
    logic [bdq_pkg::VALUE_W-1:0]     removed_value;
    logic [bdq_pkg::COUNT_OUT_W-1:0] item_count;
    logic [1:0]                      status;

    deque_scoreboard             sb = new();
    bit                          quiet = 1'b0;
    bit                          hold_long = 1'b0;
    logic [bdq_pkg::VALUE_W-1:0] pool [8];

    bounded_deque_with_delete_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .removed_value (removed_value),
        .item_count    (item_count),
        .status        (status)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [2:0] pick_opcode(bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
        if (filling) begin
            if (r < 37) return bdq_pkg::OP_PUSH_BACK;
            if (r < 72) return bdq_pkg::OP_PUSH_FRONT;
            if (r < 80) return bdq_pkg::OP_POP_BACK;
            if (r < 88) return bdq_pkg::OP_POP_FRONT;
        end else begin
            if (r < 12) return bdq_pkg::OP_PUSH_BACK;
            if (r < 22) return bdq_pkg::OP_PUSH_FRONT;
            if (r < 50) return bdq_pkg::OP_POP_BACK;
            if (r < 78) return bdq_pkg::OP_POP_FRONT;
        end
        return bdq_pkg::OP_DELETE;
    endfunction

    function automatic logic [bdq_pkg::VALUE_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return pool[$urandom_range(0, 7)];
        if (r < 70) return '0;
        if (r < 80) return '1;
        return $urandom;
    endfunction

    task automatic issue_request(input logic [2:0] op,
                                 input logic [bdq_pkg::VALUE_W-1:0] word);
        int g;
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= word;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        g = quiet ? 0 : pick_gap();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // monitor: note accepted requests, check accepted results
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) sb.check_result(removed_value, item_count, status);
            if (in_valid && !in_stall) sb.note_request(opcode, value);
        end
    end

    // result side back-pressure
    initial begin
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_long) begin
                hold_long  = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap() + 1;
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int  i;
        int  phase;
        logic [2:0] k;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        opcode   <= bdq_pkg::OP_PUSH_BACK;
        value    <= '0;
        for (i = 0; i < 8; i++) pool[i] = $urandom;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue cases
        issue_request(bdq_pkg::OP_POP_BACK, '0);
        issue_request(bdq_pkg::OP_POP_FRONT, '1);
        issue_request(bdq_pkg::OP_DELETE, '0);
        // push front into empty makes it front and back
        issue_request(bdq_pkg::OP_PUSH_FRONT, '1);
        issue_request(bdq_pkg::OP_POP_BACK, '0);
        issue_request(bdq_pkg::OP_PUSH_FRONT, 32'h8000_0001);
        issue_request(bdq_pkg::OP_POP_FRONT, '0);
        // fill from both ends, then overflow, delete a hit and a miss, and send reserved opcodes
        for (i = 0; i < DEPTH; i++) begin
            issue_request((i % 2) ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_BACK,
                          pool[i % 8] ^ i);
        end
        issue_request(bdq_pkg::OP_PUSH_BACK, '0);
        issue_request(bdq_pkg::OP_PUSH_FRONT, '1);
        issue_request(bdq_pkg::OP_DELETE, pool[4] ^ 4);
        issue_request(bdq_pkg::OP_DELETE, 32'h5A5A_A5A5);
        for (k = OP_RESERVED_LO; k != OP_RESERVED_LO - 1; k++) begin
            issue_request(k, $urandom);
            if (k == OP_RESERVED_HI) break;
        end
        wait_drained();

        for (i = 0; i < NUM_RANDOM; i++) begin
            phase = i / 100;
            quiet = (phase % 3 == 2);
            if (i == 450) hold_long = 1'b1;
            if (i == 900) wait_drained();
            issue_request(pick_opcode(phase % 2 == 0), pick_word());
        end
        quiet = 1'b0;
        wait_drained();

        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("tb: errors");
        $finish;
    end

endmodule
